// ----- sv/nge_pkg.sv -----
// Package for the gate evaluator: beat types, gate kind codes, fold request type.
// No dependencies.
package nge_pkg;

    localparam int NODE_W  = 10;
    localparam int KIND_W  = 3;
    localparam int COUNT_W = 4;
    localparam int FANIN_SLOTS = 8;
    localparam int SLOT_W  = 3;

    localparam logic [KIND_W-1:0] KIND_SET  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_AND  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OR   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NAND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NOR  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_XOR  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_NOT  = 3'd6;

    typedef struct packed {
        logic [NODE_W-1:0]  node_index;
        logic [KIND_W-1:0]  gate_kind;
        logic               set_value;
        logic [COUNT_W-1:0] fanin_count;
        logic [NODE_W-1:0]  fanin_a;
        logic [NODE_W-1:0]  fanin_b;
        logic [NODE_W-1:0]  fanin_c;
        logic [NODE_W-1:0]  fanin_d;
        logic [NODE_W-1:0]  fanin_e;
        logic [NODE_W-1:0]  fanin_f;
        logic [NODE_W-1:0]  fanin_g;
        logic [NODE_W-1:0]  fanin_h;
    } item_t;

    typedef struct packed {
        logic [NODE_W-1:0] result_node;
        logic              result_value;
    } result_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              init;
        logic              set_value;
        logic              acc;
        logic              operand;
    } fold_req_t;

    function automatic logic [NODE_W-1:0] fanin_pick(input item_t it, input logic [SLOT_W-1:0] p);
        logic [NODE_W-1:0] r;
        begin
            case (p)
                3'd0:    r = it.fanin_a;
                3'd1:    r = it.fanin_b;
                3'd2:    r = it.fanin_c;
                3'd3:    r = it.fanin_d;
                3'd4:    r = it.fanin_e;
                3'd5:    r = it.fanin_f;
                3'd6:    r = it.fanin_g;
                default: r = it.fanin_h;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- sv/nge_fold.sv -----
// Shared one-bit fold unit: start value on the first step, then one fan-in per step.
// Depends on nge_pkg.
module nge_fold
    import nge_pkg::*;
(
    input  fold_req_t req,
    output logic      acc_out
);

    always_comb
    begin
        if (req.init)
        begin
            case (req.kind)
                KIND_SET:            acc_out = req.set_value;
                KIND_AND, KIND_NAND: acc_out = 1'b1;
                KIND_OR, KIND_NOR,
                KIND_XOR:            acc_out = 1'b0;
                default:             acc_out = req.operand; // NOT and unused kind: old value
            endcase
        end
        else
        begin
            case (req.kind)
                KIND_AND, KIND_NAND: acc_out = req.acc & req.operand;
                KIND_OR, KIND_NOR:   acc_out = req.acc | req.operand;
                KIND_XOR:            acc_out = req.acc ^ req.operand;
                KIND_NOT:            acc_out = ~req.operand;
                default:             acc_out = req.acc;
            endcase
        end
    end

endmodule

// ----- sv/netlist_gate_evaluator.sv -----
// Gate evaluator top level: node value memory, sequencer and result register.
// Depends on nge_pkg and nge_fold.
//
// Usage:
//   item channel (item_valid/item_ready/item) carries one set-input or gate beat;
//   result channel (result_valid/result_ready/result) returns one beat per item
//   with the node index and its new value.
//   After reset the node memory is cleared one entry a cycle, with item_ready
//   low. Then all nodes read 0.
//   An item is taken in the idle state, then the single memory port is read once
//   for the node's old value and once per fan-in, pipelined with the fold, then
//   the node is written back. Fan-ins used: none for a set input or unused kind,
//   at most MAX_FANIN for a gate. The next item is taken only once the result
//   has been loaded into the output register.
//   The result sits in an output register; a stalled receiver holds the block in
//   its write-back state only once the next result is ready and the register is
//   still full.
module netlist_gate_evaluator
    import nge_pkg::*;
#(
    parameter int NODE_COUNT = 1024,
    parameter int MAX_FANIN  = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int AW = $clog2(NODE_COUNT);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;

    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    item_t              item_reg, item_next;
    logic [COUNT_W-1:0] step_reg, step_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               acc_reg, acc_next;
    logic               pend_reg, pend_next;
    logic               init_reg, init_next;
    logic               ok_reg, ok_next;
    logic               self_reg, self_next;
    logic               rv_reg, rv_next;
    result_t            res_reg, res_next;

    logic               mem [NODE_COUNT];
    logic               rdata_reg;
    logic [AW-1:0]      mem_addr;
    logic               mem_we;
    logic               mem_wdata;

    logic [NODE_W-1:0]  ridx;
    logic [COUNT_W-1:0] eff_cnt;
    logic               node_ok;
    logic               wval;
    fold_req_t          freq;
    logic               fold_out;

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = rv_reg;
    assign result       = res_reg;

    assign ridx = (step_reg == '0) ? item_reg.node_index
                                   : fanin_pick(item_reg, SLOT_W'(step_reg - 4'd1));
    assign node_ok = (32'(item_reg.node_index) < NODE_COUNT);
    assign wval = acc_reg ^ ((item_reg.gate_kind == KIND_NAND) ||
                             (item_reg.gate_kind == KIND_NOR));

    always_comb
    begin
        eff_cnt = '0;
        if ((item.gate_kind inside {KIND_AND, KIND_OR, KIND_NAND, KIND_NOR,
                                    KIND_XOR, KIND_NOT}))
        begin
            if (32'(item.fanin_count) > MAX_FANIN)
                eff_cnt = COUNT_W'(MAX_FANIN);
            else
                eff_cnt = item.fanin_count;
        end
    end

    assign freq.kind      = item_reg.gate_kind;
    assign freq.init      = init_reg;
    assign freq.set_value = item_reg.set_value;
    assign freq.acc       = acc_reg;
    assign freq.operand   = self_reg ? acc_reg : (rdata_reg & ok_reg);

    nge_fold u_fold
    (
        .req     (freq),
        .acc_out (fold_out)
    );

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        item_next  = item_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        pend_next  = 1'b0;
        init_next  = init_reg;
        ok_next    = ok_reg;
        self_next  = self_reg;
        rv_next    = rv_reg;
        res_next   = res_reg;
        mem_addr   = AW'(ridx);
        mem_we     = 1'b0;
        mem_wdata  = 1'b0;

        if (rv_reg && result_ready)
            rv_next = 1'b0;

        if (pend_reg)
            acc_next = fold_out;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_addr = clr_reg;
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(NODE_COUNT - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    cnt_next   = eff_cnt;
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step_reg <= cnt_reg)
                begin
                    pend_next = 1'b1;
                    init_next = (step_reg == '0);
                    ok_next   = (32'(ridx) < NODE_COUNT);
                    self_next = (step_reg != '0) && (ridx == item_reg.node_index);
                    step_next = step_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                mem_addr  = AW'(item_reg.node_index);
                mem_we    = node_ok;
                mem_wdata = wval;
                if (!rv_reg || result_ready)
                begin
                    rv_next                = 1'b1;
                    res_next.result_node   = item_reg.node_index;
                    res_next.result_value  = wval;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            step_reg  <= '0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        acc_reg  <= acc_next;
        init_reg <= init_next;
        ok_reg   <= ok_next;
        self_reg <= self_next;
        res_reg  <= res_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= MAX_FANIN)
        else $error("fan-in count above limit");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> step_reg <= cnt_reg + 4'd1)
        else $error("step past fan-in count");

    a_pend_run: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> state_reg == ST_RUN)
        else $error("read pending outside run state");

    a_write_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRITE && rv_reg && !result_ready |=> state_reg == ST_WRITE)
        else $error("result register overwritten");

endmodule

// ----- tb/sv/gate_eval_board_pkg.sv -----
// Scoreboard for the gate evaluator testbench: a shadow node table and the queue of node updates due.
// Depends on nge_pkg for the beat types and gate kind codes.
package gate_eval_board_pkg;
    import nge_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
    localparam int TABLE_SIZE = 1024;

    class gate_eval_board;
        bit          node_table [TABLE_SIZE];
        result_t     updates_due [$];
        int unsigned items_noted;
        int unsigned results_checked;
        int unsigned mismatches;
        int unsigned kind_seen [8];

        function bit read_node(int unsigned idx);
            return (idx < TABLE_SIZE) ? node_table[idx] : 1'b0;
        endfunction

        function bit evaluate_gate(item_t it);
            logic [NODE_W-1:0] slots [FANIN_SLOTS];
            int unsigned       used;
            bit                acc;
            bit                v;
            slots = '{it.fanin_a, it.fanin_b, it.fanin_c, it.fanin_d,
                      it.fanin_e, it.fanin_f, it.fanin_g, it.fanin_h};
            used = (it.fanin_count > FANIN_SLOTS) ? FANIN_SLOTS : it.fanin_count;
            case (it.gate_kind)
                KIND_SET:             acc = it.set_value;
                KIND_AND, KIND_NAND:  acc = 1'b1;
                KIND_OR, KIND_NOR,
                KIND_XOR:             acc = 1'b0;
                default:              acc = read_node(it.node_index);
            endcase
            if (it.gate_kind != KIND_SET && it.gate_kind != KIND_UNUSED)
            begin
                for (int p = 0; p < used; p++)
                begin
                    // own node reads the running fold value
                    v = (slots[p] == it.node_index) ? acc : read_node(slots[p]);
                    case (it.gate_kind)
                        KIND_AND, KIND_NAND: acc = acc & v;
                        KIND_OR, KIND_NOR:   acc = acc | v;
                        KIND_XOR:            acc = acc ^ v;
                        default:             acc = ~v;
                    endcase
                end
                if (it.gate_kind == KIND_NAND || it.gate_kind == KIND_NOR)
                    acc = ~acc;
            end
            return acc;
        endfunction

        function void note_item(item_t it);
            result_t due;
            due.result_node  = it.node_index;
            due.result_value = evaluate_gate(it);
            if (it.node_index < TABLE_SIZE)
                node_table[it.node_index] = due.result_value;
            updates_due.insert(updates_due.size(), due);
            items_noted++;
            kind_seen[it.gate_kind]++;
        endfunction

        function void check_result(result_t got);
            result_t due;
            if (updates_due.size() == 0)
            begin
                $display("%0t: unexpected result beat, node %0d value %0d",
                         $time, got.result_node, got.result_value);
                mismatches++;
                return;
            end
            due = updates_due.pop_front();
            results_checked++;
            if (got.result_node !== due.result_node)
            begin
                $display("%0t: result_node mismatch, expected %0d got %0d",
                         $time, due.result_node, got.result_node);
                mismatches++;
            end
            if (got.result_value !== due.result_value)
            begin
                $display("%0t: result_value mismatch at node %0d, expected %0d got %0d",
                         $time, due.result_node, due.result_value, got.result_value);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return updates_due.size();
        endfunction
    endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// Top of the gate evaluator testbench: clock, reset, beat drivers, result monitor and watchdog.
// Depends on nge_pkg, gate_eval_board_pkg and netlist_gate_evaluator.
module tb_top;
    import nge_pkg::*;
    import gate_eval_board_pkg::*;

    localparam int STALL_LIMIT  = 6000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int FANS_W       = FANIN_SLOTS * NODE_W;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_HOLD} sink_mode_t;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    gate_eval_board board;
    item_t          stimulus [$];
    int unsigned    idle_cycles = 0;

    netlist_gate_evaluator i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #10 clk = ~clk;

    function automatic void add_item(logic [NODE_W-1:0] node, logic [KIND_W-1:0] kind,
                                     logic setv, logic [COUNT_W-1:0] cnt,
                                     logic [FANS_W-1:0] fans);
        item_t it;
        it.node_index  = node;
        it.gate_kind   = kind;
        it.set_value   = setv;
        it.fanin_count = cnt;
        {it.fanin_a, it.fanin_b, it.fanin_c, it.fanin_d,
         it.fanin_e, it.fanin_f, it.fanin_g, it.fanin_h} = fans;
        stimulus.insert(stimulus.size(), it);
    endfunction

    function automatic logic [FANS_W-1:0] random_fans();
        logic [95:0] r;
        r = {$urandom, $urandom, $urandom};
        return r[FANS_W-1:0];
    endfunction

    function automatic logic [NODE_W-1:0] pick_node();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return NODE_W'($urandom_range(0, 1023));
    endfunction

    function automatic void add_directed_items();
        add_item(10'd0,    KIND_SET,    1'b1, 4'd0,  '0);
        add_item(10'd1023, KIND_SET,    1'b1, 4'd0,  {8{10'd1023}});
        add_item(10'd1,    KIND_SET,    1'b0, 4'd15, {8{10'h2AA}});
        add_item(10'd10,   KIND_AND,    1'b0, 4'd2,  {10'd0, 10'd1023, {6{10'd0}}});
        add_item(10'd11,   KIND_AND,    1'b0, 4'd3,  {10'd0, 10'd1, 10'd1023, {5{10'd0}}});
        // empty fan-in: start values, NOT keeps old value
        add_item(10'd12,   KIND_AND,    1'b1, 4'd0,  '0);
        add_item(10'd13,   KIND_OR,     1'b0, 4'd0,  '0);
        add_item(10'd14,   KIND_NAND,   1'b0, 4'd0,  '0);
        add_item(10'd15,   KIND_NOR,    1'b0, 4'd0,  '0);
        add_item(10'd16,   KIND_XOR,    1'b0, 4'd0,  '0);
        add_item(10'd15,   KIND_NOT,    1'b0, 4'd0,  '0);
        add_item(10'd20,   KIND_OR,     1'b1, 4'd8,  {10'd1, 10'd13, 10'd16, 10'd14,
                                                      10'd11, 10'd1, 10'd13, 10'd1023});
        add_item(10'd21,   KIND_XOR,    1'b0, 4'd8,  {10'd0, 10'd1023, 10'd10, 10'd12,
                                                      10'd15, 10'd1, 10'd13, 10'd0});
        // counts above eight saturate
        add_item(10'd22,   KIND_NAND,   1'b0, 4'd15, {10'd0, 10'd1023, 10'd10, 10'd12,
                                                      10'd15, 10'd20, 10'd1023, 10'd0});
        add_item(10'd23,   KIND_NOR,    1'b0, 4'd9,  {10'd1, 10'd13, 10'd14, 10'd16,
                                                      10'd11, 10'd1, 10'd1, 10'd0});
        add_item(10'd24,   KIND_NOT,    1'b0, 4'd3,  {10'd0, 10'd1, 10'd1023, {5{10'd0}}});
        add_item(10'd25,   KIND_NOT,    1'b1, 4'd1,  {10'd1, {7{10'd1023}}});
        // own node among the fan-ins, then unused-kind beats and a last set input
        add_item(10'd0,    KIND_AND,    1'b0, 4'd3,  {10'd1023, 10'd0, 10'd1, {5{10'd0}}});
        add_item(10'd26,   KIND_XOR,    1'b0, 4'd3,  {10'd1023, 10'd26, 10'd1023, {5{10'd0}}});
        add_item(10'd1023, KIND_NOT,    1'b0, 4'd2,  {10'd1023, 10'd1023, {6{10'd0}}});
        add_item(10'd27,   KIND_OR,     1'b0, 4'd2,  {10'd27, 10'd1023, {6{10'd0}}});
        add_item(10'd1023, KIND_UNUSED, 1'b1, 4'd8,  {8{10'd0}});
        add_item(10'd2,    KIND_UNUSED, 1'b0, 4'd0,  '0);
        add_item(10'd1023, KIND_SET,    1'b0, 4'd0,  '0);
    endfunction

    // mostly small levelised netlists over a node pool, the rest raw noise
    function automatic void build_random_items();
        int unsigned       made;
        int unsigned       cnt;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] pool [$];
        logic [FANS_W-1:0] fans;
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                add_item(pick_node(), KIND_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                         COUNT_W'($urandom_range(0, 15)), random_fans());
                made++;
            end
            else
            begin
                pool.delete();
                repeat ($urandom_range(2, 6))
                begin
                    node = pick_node();
                    add_item(node, KIND_SET, 1'($urandom_range(0, 1)), 4'd0, random_fans());
                    pool.insert(pool.size(), node);
                    made++;
                end
                repeat ($urandom_range(3, 12))
                begin
                    node = pick_node();
                    cnt  = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(1, FANIN_SLOTS);
                    fans = random_fans();
                    for (int p = 0; p < cnt && p < FANIN_SLOTS; p++)
                        fans[(FANIN_SLOTS-1-p)*NODE_W +: NODE_W] =
                            ($urandom_range(0, 9) == 0) ? node
                                                        : pool[$urandom_range(0, pool.size()-1)];
                    add_item(node, KIND_W'($urandom_range(KIND_AND, KIND_NOT)),
                             1'($urandom_range(0, 1)), COUNT_W'(cnt), fans);
                    pool.insert(pool.size(), node);
                    made++;
                end
            end
        end
    endfunction

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin : source_proc
        int unsigned burst_left;
        board = new;
        add_directed_items();
        build_random_items();
        wait (rst_n === 1'b1);
        @(negedge clk);
        burst_left = $urandom_range(1, 30);
        foreach (stimulus[i])
        begin
            item       <= stimulus[i];
            item_valid <= 1'b1;
            @(posedge clk);
            while (!item_ready)
                @(posedge clk);
            board.note_item(stimulus[i]);
            @(negedge clk);
            burst_left--;
            if (burst_left == 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(negedge clk);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 30);
            end
        end
        item_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d items: %0d set-input, %0d gate, %0d unused-kind beats",
                 board.items_noted, board.kind_seen[KIND_SET],
                 board.items_noted - board.kind_seen[KIND_SET] - board.kind_seen[KIND_UNUSED],
                 board.kind_seen[KIND_UNUSED]);
        $display("Checked %0d result beats, %0d mismatches",
                 board.results_checked, board.mismatches);
        if (board.mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin : sink_proc
        sink_mode_t  mode;
        int unsigned left;
        int unsigned hold;
        hold = 0;
        forever
        begin
            mode = sink_mode_t'($urandom_range(0, 3));
            left = $urandom_range(50, 400);
            while (left > 0)
            begin
                @(negedge clk);
                case (mode)
                    SINK_OPEN:   result_ready <= 1'b1;
                    SINK_COIN:   result_ready <= ($urandom_range(0, 1) == 1);
                    SINK_SPARSE: result_ready <= ($urandom_range(0, 7) == 0);
                    default:
                    begin
                        if (hold > 0)
                        begin
                            result_ready <= 1'b0;
                            hold--;
                        end
                        else
                        begin
                            result_ready <= 1'b1;
                            if ($urandom_range(0, 5) == 0)
                                hold = $urandom_range(5, 30);
                        end
                    end
                endcase
                left--;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_result(result);
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("tb_top failed");
            $finish;
        end
    end

endmodule
